[rtl/lsd_pkg.sv]
// Shared types, register codes and reset values for the loudness segment detector.
package lsd_pkg;

    localparam int LSD_POS_BITS  = 32;
    localparam int LSD_MAX_CHUNK = 4096;
    localparam int LSD_LOUD_W    = 16;
    localparam int LSD_FRAMES_W  = 13;
    localparam int LSD_SEG_W     = 32;
    localparam int LSD_CFG_W     = 32;
    localparam int LSD_CFG_IDX_W = 2;
    localparam int LSD_OQ_DEPTH  = 4;

    localparam logic signed [LSD_LOUD_W-1:0] LSD_ATTACK_RST  = -16'sd7424;
    localparam logic signed [LSD_LOUD_W-1:0] LSD_RELEASE_RST = -16'sd8704;
    localparam logic [LSD_CFG_W-1:0]         LSD_MIN_GAP_RST    = 32'd24000;
    localparam logic [LSD_CFG_W-1:0]         LSD_MIN_PHRASE_RST = 32'd240000;

    typedef enum logic [LSD_CFG_IDX_W-1:0] {
        LSD_REG_ATTACK     = 2'd0,
        LSD_REG_RELEASE    = 2'd1,
        LSD_REG_MIN_GAP    = 2'd2,
        LSD_REG_MIN_PHRASE = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic signed [LSD_LOUD_W-1:0] attack_lvl;
        logic signed [LSD_LOUD_W-1:0] release_lvl;
        logic [LSD_CFG_W-1:0]         min_gap;
        logic [LSD_CFG_W-1:0]         min_phrase;
    } t_cfg;

    typedef struct packed {
        logic [LSD_SEG_W-1:0] seg_start;
        logic [LSD_SEG_W-1:0] seg_end;
        logic                 last;
    } t_result;

    // Up to two results per request, packed so that v1 implies v0.
    typedef struct packed {
        logic    v0;
        t_result r0;
        logic    v1;
        t_result r1;
    } t_push;

endpackage

[rtl/loudness_segment_detector.sv]
// Top level: loud region detector with gap merge and minimum length filter.
//
//  channel  | direction | handshake               | payload
//  s_axis   | in        | tvalid/tready           | tdata, tuser, tlast (one chunk)
//  m_axis   | out       | tvalid/tready           | tdata, tlast (one region)
//  cfg      | in        | i_cfg_we, no wait       | i_cfg_addr, i_cfg_wdata
//
// A chunk request is taken when tvalid and tready meet, and its regions (zero to
// two) land in the result queue at the edge that takes it; one chunk per cycle while
// the queue has room for two results, so the output port's drain rate sets the pace.
// Reset (synchronous, active low) clears position, detector state and queue,
// and loads the default levels and thresholds. A stalled output backs up into
// the four-entry queue and then drops s_axis_tready.
module loudness_segment_detector import lsd_pkg::*; #(
    parameter int POS_BITS = LSD_POS_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [31:0]              s_axis_tdata,  // loudness[15:0], chunk_frames[28:16]
    input  logic                     s_axis_tuser,  // loudness_valid[0]
    input  logic                     s_axis_tlast,  // end_of_stream
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [63:0]              m_axis_tdata,  // seg_start[31:0], seg_end[63:32]
    output logic                     m_axis_tlast,  // last_of_run
    input  logic                     i_cfg_we,
    input  logic [LSD_CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [LSD_CFG_W-1:0]     i_cfg_wdata
);

    t_cfg    w_cfg;
    t_push   w_push;
    t_result w_head;
    logic    w_acc;
    logic    w_space;

    assign s_axis_tready = w_space;
    assign w_acc         = s_axis_tvalid & w_space;

    lsd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_addr),
        .i_wdata (i_cfg_wdata),
        .o_cfg   (w_cfg)
    );

    lsd_core #(
        .POS_BITS (POS_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_acc        (w_acc),
        .i_loud       (s_axis_tdata[LSD_LOUD_W-1:0]),
        .i_loud_valid (s_axis_tuser),
        .i_frames     (s_axis_tdata[LSD_LOUD_W +: LSD_FRAMES_W]),
        .i_eos        (s_axis_tlast),
        .i_cfg        (w_cfg),
        .o_push       (w_push)
    );

    lsd_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_space (w_space),
        .o_head  (w_head)
    );

    assign m_axis_tdata = {w_head.seg_end, w_head.seg_start};
    assign m_axis_tlast = w_head.last;

endmodule

[rtl/lsd_cfg.sv]
// Configuration register file: levels and frame thresholds.
module lsd_cfg import lsd_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_we,
    input  logic [LSD_CFG_IDX_W-1:0] i_idx,
    input  logic [LSD_CFG_W-1:0]     i_wdata,
    output t_cfg                     o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.attack_lvl  <= LSD_ATTACK_RST;
            r_cfg.release_lvl <= LSD_RELEASE_RST;
            r_cfg.min_gap     <= LSD_MIN_GAP_RST;
            r_cfg.min_phrase  <= LSD_MIN_PHRASE_RST;
        end else if (i_we) begin
            unique case (t_reg_idx'(i_idx))
                LSD_REG_ATTACK:     r_cfg.attack_lvl  <= i_wdata[LSD_LOUD_W-1:0];
                LSD_REG_RELEASE:    r_cfg.release_lvl <= i_wdata[LSD_LOUD_W-1:0];
                LSD_REG_MIN_GAP:    r_cfg.min_gap     <= i_wdata;
                LSD_REG_MIN_PHRASE: r_cfg.min_phrase  <= i_wdata;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/lsd_core.sv]
// Detector state: frame position, hysteresis, gap merge and length filter.
module lsd_core import lsd_pkg::*; #(
    parameter int POS_BITS = LSD_POS_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_acc,
    input  logic signed [LSD_LOUD_W-1:0] i_loud,
    input  logic                         i_loud_valid,
    input  logic [LSD_FRAMES_W-1:0]      i_frames,
    input  logic                         i_eos,
    input  t_cfg                         i_cfg,
    output t_push                        o_push
);

    localparam int CMP_W = (POS_BITS > LSD_SEG_W) ? POS_BITS : LSD_SEG_W;

    logic [POS_BITS-1:0] r_pos, n_pos;
    logic                r_active, n_active;
    logic [POS_BITS-1:0] r_open_start, n_open_start;
    logic                r_pend_v, n_pend_v;
    logic [POS_BITS-1:0] r_pend_start, n_pend_start;
    logic [POS_BITS-1:0] r_pend_end, n_pend_end;

    logic [LSD_FRAMES_W-1:0] w_frames;
    logic [POS_BITS:0]       w_sum;
    logic [POS_BITS-1:0]     w_pos;
    logic                    w_open, w_close, w_active1, w_reg_v;
    logic [POS_BITS-1:0]     w_open_start1, w_gap, w_len_old, w_len_new;
    logic                    w_merge, w_old_ok, w_out1_v, w_out2_v;
    logic                    w_pv2;
    logic [POS_BITS-1:0]     w_ps2, w_pe2;
    t_result                 w_res1, w_res2;

    // Clamp the chunk, then advance the position with saturation.
    assign w_frames = (int'(i_frames) > LSD_MAX_CHUNK) ?
                      LSD_FRAMES_W'(LSD_MAX_CHUNK) : i_frames;
    assign w_sum    = {1'b0, r_pos} + (POS_BITS+1)'(w_frames);
    assign w_pos    = w_sum[POS_BITS] ? '1 : w_sum[POS_BITS-1:0];

    always_comb begin
        w_open  = i_loud_valid && !r_active &&
                  ($signed(i_loud) >= $signed(i_cfg.attack_lvl));
        w_close = i_loud_valid && r_active &&
                  ($signed(i_loud) < $signed(i_cfg.release_lvl));
        w_active1     = w_open | (r_active & ~w_close);
        w_open_start1 = w_open ? w_pos : r_open_start;

        // A region closes on release, or at end of stream while still open.
        w_reg_v = w_close | (i_eos & w_active1);

        w_gap     = (w_open_start1 >= r_pend_end) ? (w_open_start1 - r_pend_end) : '0;
        w_merge   = r_pend_v && (CMP_W'(w_gap) < CMP_W'(i_cfg.min_gap));
        w_len_old = r_pend_end - r_pend_start;
        w_old_ok  = CMP_W'(w_len_old) >= CMP_W'(i_cfg.min_phrase);
        w_out1_v  = w_reg_v & r_pend_v & ~w_merge & w_old_ok;

        if (w_reg_v) begin
            w_pv2 = 1'b1;
            w_ps2 = w_merge ? r_pend_start : w_open_start1;
            w_pe2 = w_pos;
        end else begin
            w_pv2 = r_pend_v;
            w_ps2 = r_pend_start;
            w_pe2 = r_pend_end;
        end
        w_len_new = w_pe2 - w_ps2;
        w_out2_v  = i_eos & w_pv2 & (CMP_W'(w_len_new) >= CMP_W'(i_cfg.min_phrase));

        w_res1.seg_start = LSD_SEG_W'(r_pend_start);
        w_res1.seg_end   = LSD_SEG_W'(r_pend_end);
        w_res1.last      = ~w_out2_v;
        w_res2.seg_start = LSD_SEG_W'(w_ps2);
        w_res2.seg_end   = LSD_SEG_W'(w_pe2);
        w_res2.last      = 1'b1;

        // Pack so the first valid result sits in slot 0.
        if (w_out1_v) begin
            o_push.v0 = i_acc;
            o_push.r0 = w_res1;
            o_push.v1 = i_acc & w_out2_v;
            o_push.r1 = w_res2;
        end else begin
            o_push.v0 = i_acc & w_out2_v;
            o_push.r0 = w_res2;
            o_push.v1 = 1'b0;
            o_push.r1 = w_res2;
        end

        if (i_eos) begin
            n_pos        = '0;
            n_active     = 1'b0;
            n_open_start = '0;
            n_pend_v     = 1'b0;
            n_pend_start = '0;
            n_pend_end   = '0;
        end else begin
            n_pos        = w_pos;
            n_active     = w_active1;
            n_open_start = w_open_start1;
            n_pend_v     = w_pv2;
            n_pend_start = w_ps2;
            n_pend_end   = w_pe2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_active     <= 1'b0;
            r_open_start <= '0;
            r_pend_v     <= 1'b0;
            r_pend_start <= '0;
            r_pend_end   <= '0;
        end else if (i_acc) begin
            r_pos        <= n_pos;
            r_active     <= n_active;
            r_open_start <= n_open_start;
            r_pend_v     <= n_pend_v;
            r_pend_start <= n_pend_start;
            r_pend_end   <= n_pend_end;
        end
    end

`ifndef SYNTHESIS
    a_eos_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_acc && i_eos) |=> (!r_pend_v && !r_active && r_pos == '0))
        else $error("state not cleared after end of stream");

    a_pend_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_v |-> (r_pend_end >= r_pend_start))
        else $error("pending region ends before it starts");

    a_two_results: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.v1 |-> (o_push.v0 && !o_push.r0.last && o_push.r1.last))
        else $error("two results without proper packing or last marks");
`endif

endmodule

[rtl/lsd_outq.sv]
// Result queue: takes up to two results a cycle, hands out one.
module lsd_outq import lsd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    input  logic    i_ready,
    output logic    o_valid,
    output logic    o_space,
    output t_result o_head
);

    localparam int DEPTH = LSD_OQ_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_result          r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] w_npush;
    logic             w_pop;

    assign w_npush = CNT_W'(i_push.v0) + CNT_W'(i_push.v1);
    assign w_pop   = o_valid & i_ready;
    assign o_valid = (r_count != '0);
    // Keep room for the two results one request may bring.
    assign o_space = (r_count <= CNT_W'(DEPTH - 2));
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            r_mem[r_wr] <= i_push.r0;
        end
        if (i_push.v1) begin
            r_mem[r_wr + PTR_W'(1)] <= i_push.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + PTR_W'(w_npush);
            r_rd    <= r_rd + PTR_W'(w_pop);
            r_count <= r_count + w_npush - CNT_W'(w_pop);
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("result queue overflow");

    a_pair_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.v0 && i_push.v1) |-> (r_count <= CNT_W'(DEPTH - 2)))
        else $error("two results pushed without room");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !i_push.v0) |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("queue count wrong after pop");
`endif

endmodule
